// ----- rtl/rabc_pkg.sv -----
package rabc_pkg;

  // Default canvas store geometry.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Configuration register width and register indexes.
  localparam int CFG_W = 9;
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] CANVAS_DIM_RESET = 9'd256;

  // Width used for coordinate and size compares; holds 4096.
  localparam int DIM_W = 13;

  // Stream payload widths.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;

  // Operation codes carried on in_tuser.
  localparam logic OP_BLEND = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Canvas word layout: red in the top byte, alpha in the bottom byte.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  // Exact floor(x / 255) for any x below 65280, which covers every weighted
  // channel sum of the blend.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

// ----- rtl/rabc_ram.sv -----
module rabc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rgba_alpha_blend_canvas_unit.sv -----
// Channel   Dir  Handshake             Contents
// in_       in   in_tvalid/in_tready   word: op on tuser; x, y, source RGBA on tdata
// out_      out  out_tvalid/out_tready word: stored RGBA on tdata, outside flag on tuser
// cfg_      in   cfg_we                canvas width (index 0), canvas height (index 1)
//
// A blend word inside the canvas passes accept with the canvas read, products and
// sums, then divide and write back. A read word inside passes accept with the read
// and the capture of the stored word before the output register; a read word
// outside goes there straight from accept. A word outside the canvas that blends is
// dropped in its accept cycle. After reset the block clears all MAX_WIDTH*MAX_HEIGHT
// pixels (65536 by default), one pixel a cycle, and accepts no word until done. The
// output register lets the next word enter while a result waits; a read result that
// finds it still full holds until it drains.
module rgba_alpha_blend_canvas_unit #(
  parameter int MAX_WIDTH  = rabc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rabc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Fields from bit 0: pos_x[10:0], pos_y[21:11], src_red[29:22],
  // src_green[37:30], src_blue[45:38], src_alpha[53:46], zero fill [55:54].
  input  logic [rabc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: operation.
  input  logic                             in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: out_red[7:0], out_green[15:8], out_blue[23:16],
  // out_alpha[31:24].
  output logic [rabc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Fields from bit 0: outside.
  output logic                             out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [rabc_pkg::CFG_W-1:0]       cfg_wdata
);

  import rabc_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [AW-1:0] clr_addr_r;

  logic [CFG_W-1:0] cfg_width_r, cfg_height_r;

  // Input word fields.
  logic [10:0] pos_x, pos_y;
  pixel_t      src_pix;

  assign pos_x         = in_tdata[10:0];
  assign pos_y         = in_tdata[21:11];
  assign src_pix.red   = in_tdata[29:22];
  assign src_pix.green = in_tdata[37:30];
  assign src_pix.blue  = in_tdata[45:38];
  assign src_pix.alpha = in_tdata[53:46];

  // Register values above the store size act as the store size.
  logic [DIM_W-1:0] w_eff, h_eff, x_cmp, y_cmp;
  logic             in_canvas;
  logic [AW-1:0]    addr_calc;

  always_comb begin
    w_eff = (DIM_W'(cfg_width_r) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                      : DIM_W'(cfg_width_r);
    h_eff = (DIM_W'(cfg_height_r) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                        : DIM_W'(cfg_height_r);
    x_cmp = DIM_W'(pos_x[9:0]);
    y_cmp = DIM_W'(pos_y[9:0]);
    in_canvas = !pos_x[10] && !pos_y[10] && (x_cmp < w_eff) && (y_cmp < h_eff);
    // Row-major layout fixed by the store size, not by the registers.
    addr_calc = AW'(AW'(pos_y[9:0]) * AW'(MAX_WIDTH)) + AW'(pos_x[9:0]);
  end

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Item registers held for the duration of one word.
  logic          op_r;
  logic [AW-1:0] addr_r;
  pixel_t        src_r;

  // Canvas memory.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  pixel_t        mem_wdata, mem_rdata, blend_pix;

  rabc_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_canvas (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_acc),
    .raddr (addr_calc),
    .rdata (mem_rdata)
  );

  // First blend stage: weighted channel sums, registered before the divide.
  // Each sum is at most 255*255, so 16 bits hold it.
  logic [7:0]  inv_a;
  logic [15:0] sum_red, sum_green, sum_blue;
  logic [15:0] sum_red_r, sum_green_r, sum_blue_r, dst_alpha_r;

  always_comb begin
    inv_a     = 8'd255 - src_r.alpha;
    sum_red   = 16'(src_r.red * src_r.alpha)
              + 16'(mem_rdata.red * inv_a);
    sum_green = 16'(src_r.green * src_r.alpha)
              + 16'(mem_rdata.green * inv_a);
    sum_blue  = 16'(src_r.blue * src_r.alpha)
              + 16'(mem_rdata.blue * inv_a);
  end

  // Second blend stage: divide by 255 and form the new alpha.
  logic [8:0] alpha_sum;

  always_comb begin
    alpha_sum       = {1'b0, src_r.alpha} + {1'b0, div255(dst_alpha_r)};
    blend_pix.red   = div255(sum_red_r);
    blend_pix.green = div255(sum_green_r);
    blend_pix.blue  = div255(sum_blue_r);
    blend_pix.alpha = alpha_sum[8] ? 8'hFF : alpha_sum[7:0];
  end

  always_comb begin
    mem_we    = (state_r == S_CLEAR) || (state_r == S_WRITE);
    mem_waddr = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
    mem_wdata = (state_r == S_CLEAR) ? '0 : blend_pix;
  end

  // Result waiting to go out, and the output register itself.
  pixel_t pix_r;
  logic   outside_r;
  pixel_t out_pix_r;
  logic   out_outside_r;
  logic   out_valid_r, out_valid_nxt;
  logic   out_load;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_canvas) begin
            state_nxt = S_READ;
          end else if (in_tuser == OP_READ) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_READ: begin
        state_nxt = (op_r == OP_BLEND) ? S_WRITE : S_OUT;
      end
      S_WRITE: begin
        state_nxt = S_IDLE;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
      cfg_width_r  <= CANVAS_DIM_RESET;
      cfg_height_r <= CANVAS_DIM_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_IDX_WIDTH:  cfg_width_r  <= cfg_wdata;
          CFG_IDX_HEIGHT: cfg_height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_tuser;
      addr_r    <= addr_calc;
      src_r     <= src_pix;
      pix_r     <= '0;
      outside_r <= !in_canvas;
    end
    if (state_r == S_READ) begin
      sum_red_r   <= sum_red;
      sum_green_r <= sum_green;
      sum_blue_r  <= sum_blue;
      dst_alpha_r <= 16'(mem_rdata.alpha * inv_a);
      pix_r       <= mem_rdata;
    end
    if (out_load) begin
      out_pix_r     <= pix_r;
      out_outside_r <= outside_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pix_r.alpha, out_pix_r.blue, out_pix_r.green, out_pix_r.red};
  assign out_tuser  = out_outside_r;

endmodule
